// ----- rtl/core/mbtb_pkg.sv -----
// Package for the multi-block-ahead branch target buffer.
// Holds request/response types, size defaults and entry codes; no dependencies.
`timescale 1ns / 1ps
package mbtb_pkg;
   localparam int TABLE_SETS_DEF        = 2048;
   localparam int TABLE_WAYS_DEF        = 4;
   localparam int INDIRECT_ENTRIES_DEF  = 4096;
   localparam int STACK_DEPTH_DEF       = 64;
   localparam int CALL_SIZE_ENTRIES_DEF = 1024;

   localparam int ADDR_WIDTH = 64;
   localparam int KEY_WIDTH  = 62;
   localparam int SIZE_WIDTH = 4;
   localparam logic [ADDR_WIDTH-1:0] SIZE_LIMIT = 64'd10;
   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 4'd4;

   localparam logic [1:0] TR_TAKEN = 2'd0;
   localparam logic [1:0] TR_NOT   = 2'd1;
   localparam logic [1:0] TR_CALL  = 2'd2;

   localparam logic [1:0] K_INDIRECT = 2'd0;
   localparam logic [1:0] K_RETURN   = 2'd1;
   localparam logic [1:0] K_ALWAYS   = 2'd2;
   localparam logic [1:0] K_COND     = 2'd3;

   localparam logic [2:0] BK_JUMP     = 3'd0;
   localparam logic [2:0] BK_INDIRECT = 3'd1;
   localparam logic [2:0] BK_COND     = 3'd2;
   localparam logic [2:0] BK_CALL     = 3'd3;
   localparam logic [2:0] BK_IND_CALL = 3'd4;
   localparam logic [2:0] BK_RETURN   = 3'd5;
   localparam logic [2:0] BK_OTHER    = 3'd6;
   localparam logic [2:0] BK_UNUSED   = 3'd7;

   localparam logic MODE_PREDICT = 1'b0;
   localparam logic MODE_UPDATE  = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [ADDR_WIDTH-1:0] ip;
      logic [ADDR_WIDTH-1:0] resolved_target;
      logic                  taken;
      logic [2:0]            branch_kind;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] pred_target;
      logic                  unconditional;
      logic                  hit;
   } rsp_type;
endpackage

// ----- rtl/core/mbtb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mbtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- rtl/core/multi_block_ahead_branch_target_buffer_core.sv -----
// Multi-block-ahead branch target buffer top level.
// Depends on mbtb_pkg and mbtb_ram.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. A predict request
// holds busy through states S_EXEC and S_PRED: the main set, indirect and
// return stack memories are read at acceptance and the call size memory in
// the cycle after. Its response is registered in S_PRED and shown on rsp_data,
// marked by rsp_valid, while busy is already low. An update returns nothing and
// holds busy through S_EXEC, and for calls also through S_MOD, where a remainder
// unit (8 address bits a cycle) reduces the pushed address modulo the call size
// table depth before it is stored with the address on the return stack. After
// reset a clearing pass over max(TABLE_SETS, INDIRECT_ENTRIES,
// CALL_SIZE_ENTRIES) entries (4096 by default) holds busy high. The receiver
// cannot stall: each result is shown for exactly one cycle.
module multi_block_ahead_branch_target_buffer_core
   import mbtb_pkg::*;
#(
   parameter int TABLE_SETS        = TABLE_SETS_DEF,
   parameter int TABLE_WAYS        = TABLE_WAYS_DEF,
   parameter int INDIRECT_ENTRIES  = INDIRECT_ENTRIES_DEF,
   parameter int STACK_DEPTH       = STACK_DEPTH_DEF,
   parameter int CALL_SIZE_ENTRIES = CALL_SIZE_ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int SETW = $clog2(TABLE_SETS);
   localparam int INDW = $clog2(INDIRECT_ENTRIES);
   localparam int CSW  = $clog2(CALL_SIZE_ENTRIES);
   localparam int SPW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNTW = $clog2(STACK_DEPTH + 1);
   localparam int AGEW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int WAYW = AGEW;
   localparam int CLR_A = (TABLE_SETS > INDIRECT_ENTRIES) ? TABLE_SETS : INDIRECT_ENTRIES;
   localparam int CLR_DEPTH = (CLR_A > CALL_SIZE_ENTRIES) ? CLR_A : CALL_SIZE_ENTRIES;
   localparam int CLRW = $clog2(CLR_DEPTH) + 1;

   typedef struct packed {
      logic                  valid;
      logic [AGEW-1:0]       age;
      logic [KEY_WIDTH-1:0]  key;
      logic [1:0]            trans;
      logic [1:0]            kind;
      logic [ADDR_WIDTH-1:0] target;
   } way_type;
   typedef way_type [TABLE_WAYS-1:0] row_type;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_PRED, S_MOD} state_type;

   state_type             state_ff;
   logic [CLRW-1:0]       cnt_ff;
   req_type               req_ff;
   logic [INDW-1:0]       idx_ff;
   logic [INDW-1:0]       hist_ff;
   logic [SPW-1:0]        top_ff;
   logic [CNTW-1:0]       count_ff;
   logic [ADDR_WIDTH-1:0] last_ff;
   logic [1:0]            last_tr_ff;
   logic [ADDR_WIDTH-1:0] mod_ip_ff;
   logic [CSW:0]          mod_r_ff;
   logic [2:0]            mod_step_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  accept;
   logic [$bits(row_type)-1:0] main_rd;
   logic                  main_we;
   logic [$bits(row_type)-1:0] main_wd;
   logic                  ind_we;
   logic [ADDR_WIDTH-1:0] ind_wd;
   logic [ADDR_WIDTH-1:0] ind_rd;
   logic                  cs_we;
   logic [CSW-1:0]        cs_wa;
   logic [SIZE_WIDTH-1:0] cs_wd;
   logic [SIZE_WIDTH-1:0] cs_rd;
   logic                  stk_we;
   logic [ADDR_WIDTH+CSW-1:0] stk_wd;
   logic [ADDR_WIDTH+CSW-1:0] stk_rd;

   row_type               row_q;
   row_type               row_in;
   logic [KEY_WIDTH-1:0]  key_q;
   logic                  hit_any;
   logic [WAYW-1:0]       hit_way;
   logic                  inv_any;
   logic [WAYW-1:0]       inv_way;
   logic [WAYW-1:0]       old_way;
   logic [WAYW-1:0]       tw;
   logic                  do_touch;
   logic [AGEW:0]         old_age;
   logic                  is_call;
   logic                  is_ind;
   logic                  is_cond;
   logic                  is_ret;
   logic                  tgt_known;
   logic [1:0]            kind_in;
   logic [1:0]            tr_in;
   logic [ADDR_WIDTH-1:0] ra;
   logic [CSW-1:0]        ra_rem;
   logic [ADDR_WIDTH-1:0] ra_diff;
   logic [ADDR_WIDTH-1:0] mag;
   logic                  pop;
   logic [SPW-1:0]        top_inc;
   logic [SPW-1:0]        top_dec;
   rsp_type               rsp_in;
   logic [CSW:0]          mod_r_in;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mbtb_ram #(.WIDTH($bits(row_type)), .DEPTH(TABLE_SETS)) u_main (
      .clock   (clock),
      .wr_en   (main_we),
      .wr_addr (state_ff == S_CLEAR ? cnt_ff[SETW-1:0] : last_ff[SETW+1:2]),
      .wr_data (main_wd),
      .rd_en   (accept),
      .rd_addr (last_ff[SETW+1:2]),
      .rd_data (main_rd)
   );

   mbtb_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(INDIRECT_ENTRIES)) u_ind (
      .clock   (clock),
      .wr_en   (ind_we),
      .wr_addr (state_ff == S_CLEAR ? cnt_ff[INDW-1:0] : idx_ff),
      .wr_data (ind_wd),
      .rd_en   (accept),
      .rd_addr (req_data.ip[INDW+1:2] ^ hist_ff),
      .rd_data (ind_rd)
   );

   // return address and its call size index
   mbtb_ram #(.WIDTH(ADDR_WIDTH + CSW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (top_ff),
      .wr_data (stk_wd),
      .rd_en   (accept),
      .rd_addr (top_ff),
      .rd_data (stk_rd)
   );

   mbtb_ram #(.WIDTH(SIZE_WIDTH), .DEPTH(CALL_SIZE_ENTRIES)) u_size (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_wa),
      .wr_data (cs_wd),
      .rd_en   (state_ff == S_EXEC),
      .rd_addr (ra_rem),
      .rd_data (cs_rd)
   );

   always_comb begin
      row_q = row_type'(main_rd);
      key_q = last_ff[ADDR_WIDTH-1:2];
      hit_any = 1'b0;
      hit_way = '0;
      inv_any = 1'b0;
      inv_way = '0;
      old_way = '0;
      for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
         if (row_q[w].valid && row_q[w].key == key_q && row_q[w].trans == last_tr_ff) begin
            hit_any = 1'b1;
            hit_way = WAYW'(w);
         end
         if (!row_q[w].valid) begin
            inv_any = 1'b1;
            inv_way = WAYW'(w);
         end
         if (row_q[w].age == AGEW'(TABLE_WAYS - 1)) begin
            old_way = WAYW'(w);
         end
      end

      is_call = (req_ff.branch_kind == BK_CALL) || (req_ff.branch_kind == BK_IND_CALL);
      is_ind  = (req_ff.branch_kind == BK_INDIRECT) || (req_ff.branch_kind == BK_IND_CALL);
      is_cond = (req_ff.branch_kind == BK_COND) || (req_ff.branch_kind == BK_OTHER);
      is_ret  = (req_ff.branch_kind == BK_RETURN);
      tgt_known = (req_ff.resolved_target != '0);

      if (is_call) begin
         tr_in = TR_CALL;
      end else if (req_ff.taken && !is_ret) begin
         tr_in = TR_TAKEN;
      end else begin
         tr_in = TR_NOT;
      end
      if (is_ind) begin
         kind_in = K_INDIRECT;
      end else if (is_ret) begin
         kind_in = K_RETURN;
      end else if (is_cond) begin
         kind_in = K_COND;
      end else begin
         kind_in = K_ALWAYS;
      end

      tw = hit_any ? hit_way : (inv_any ? inv_way : old_way);
      do_touch = hit_any || (req_ff.mode == MODE_UPDATE && tgt_known);
      old_age = row_q[tw].valid ? {1'b0, row_q[tw].age} : (AGEW + 1)'(TABLE_WAYS);

      row_in = row_q;
      if (do_touch) begin
         for (int v = 0; v < TABLE_WAYS; v++) begin
            if (WAYW'(v) == tw) begin
               row_in[v].age = '0;
            end else if (row_q[v].valid && {1'b0, row_q[v].age} < old_age) begin
               row_in[v].age = row_q[v].age + 1'b1;
            end
         end
      end
      if (req_ff.mode == MODE_UPDATE && tgt_known) begin
         row_in[tw].target = req_ff.resolved_target;
         row_in[tw].kind   = kind_in;
         if (!hit_any) begin
            row_in[tw].valid = 1'b1;
            row_in[tw].key   = key_q;
            row_in[tw].trans = last_tr_ff;
         end
      end

      ra      = stk_rd[ADDR_WIDTH+CSW-1:CSW];
      ra_rem  = stk_rd[CSW-1:0];
      ra_diff = ra - req_ff.resolved_target;
      mag     = ra_diff[ADDR_WIDTH-1] ? ('0 - ra_diff) : ra_diff;
      pop     = is_ret && (count_ff != '0);
      top_inc = (top_ff == SPW'(STACK_DEPTH - 1)) ? '0 : top_ff + 1'b1;
      top_dec = (top_ff == '0) ? SPW'(STACK_DEPTH - 1) : top_ff - 1'b1;

      rsp_in.pred_target   = '0;
      rsp_in.unconditional = 1'b0;
      rsp_in.hit           = hit_any;
      if (hit_any) begin
         rsp_in.pred_target = row_q[hit_way].target;
         case (row_q[hit_way].kind)
            K_RETURN: begin
               rsp_in.unconditional = 1'b1;
               rsp_in.pred_target = (count_ff == '0) ? '0 : ra + ADDR_WIDTH'(cs_rd);
            end
            K_INDIRECT: begin
               rsp_in.unconditional = 1'b1;
               rsp_in.pred_target = ind_rd;
            end
            K_COND: rsp_in.unconditional = 1'b0;
            default: rsp_in.unconditional = 1'b1;
         endcase
      end

      mod_r_in = mod_r_ff;
      for (int b = 0; b < 8; b++) begin
         mod_r_in = {mod_r_in[CSW-1:0], mod_ip_ff[ADDR_WIDTH-1-b]};
         if (mod_r_in >= (CSW + 1)'(CALL_SIZE_ENTRIES)) begin
            mod_r_in = mod_r_in - (CSW + 1)'(CALL_SIZE_ENTRIES);
         end
      end

      main_we = 1'b0;
      main_wd = main_rd;
      ind_we  = 1'b0;
      ind_wd  = req_ff.resolved_target;
      cs_we   = 1'b0;
      cs_wa   = ra_rem;
      cs_wd   = mag[SIZE_WIDTH-1:0];
      stk_we  = 1'b0;
      stk_wd  = {req_ff.ip, mod_r_in[CSW-1:0]};
      case (state_ff)
         S_CLEAR: begin
            main_we = (cnt_ff < CLRW'(TABLE_SETS));
            main_wd = '0;
            ind_we  = (cnt_ff < CLRW'(INDIRECT_ENTRIES));
            ind_wd  = '0;
            cs_we   = (cnt_ff < CLRW'(CALL_SIZE_ENTRIES));
            cs_wa   = cnt_ff[CSW-1:0];
            cs_wd   = SIZE_RESET;
         end
         S_EXEC: begin
            main_we = (req_ff.mode == MODE_UPDATE);
            main_wd = row_in;
            ind_we  = (req_ff.mode == MODE_UPDATE) && is_ind;
            cs_we   = (req_ff.mode == MODE_UPDATE) && pop && (mag <= SIZE_LIMIT);
         end
         S_PRED: begin
            main_we = 1'b1;
            main_wd = row_in;
         end
         S_MOD: begin
            stk_we = (mod_step_ff == 3'd7);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         hist_ff      <= '0;
         top_ff       <= '0;
         count_ff     <= '0;
         last_ff      <= '0;
         last_tr_ff   <= TR_NOT;
         rsp_valid_ff <= 1'b0;
         mod_step_ff  <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CLRW'(CLR_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  req_ff   <= req_data;
                  idx_ff   <= req_data.ip[INDW+1:2] ^ hist_ff;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (req_ff.mode == MODE_PREDICT) begin
                  state_ff <= S_PRED;
               end else begin
                  if (is_call) begin
                     top_ff <= top_inc;
                     if (count_ff != CNTW'(STACK_DEPTH)) begin
                        count_ff <= count_ff + 1'b1;
                     end
                     mod_ip_ff   <= req_ff.ip;
                     mod_r_ff    <= '0;
                     mod_step_ff <= '0;
                     state_ff    <= S_MOD;
                  end else begin
                     if (pop) begin
                        top_ff   <= top_dec;
                        count_ff <= count_ff - 1'b1;
                     end
                     state_ff <= S_IDLE;
                  end
                  if (is_cond) begin
                     hist_ff <= {hist_ff[INDW-2:0], req_ff.taken};
                  end
                  last_ff    <= req_ff.ip;
                  last_tr_ff <= tr_in;
               end
            end
            S_PRED: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= rsp_in;
               state_ff     <= S_IDLE;
            end
            S_MOD: begin
               mod_r_ff    <= mod_r_in;
               mod_ip_ff   <= {mod_ip_ff[ADDR_WIDTH-9:0], 8'd0};
               mod_step_ff <= mod_step_ff + 1'b1;
               if (mod_step_ff == 3'd7) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while a request is in flight");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(STACK_DEPTH)) else $error("stack count overflow");
`endif
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for multi_block_ahead_branch_target_buffer_core.
// Drives predict/update requests, predicts each response with a behavioral model
// of the tables and return stack; depends on mbtb_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
   import mbtb_pkg::*;

   localparam int SETS  = TABLE_SETS_DEF;
   localparam int WAYS  = TABLE_WAYS_DEF;
   localparam int IND_N = INDIRECT_ENTRIES_DEF;
   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int CSN   = CALL_SIZE_ENTRIES_DEF;
   localparam longint LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   multi_block_ahead_branch_target_buffer_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state
   logic [KEY_WIDTH-1:0]  m_key [SETS*WAYS];
   logic [ADDR_WIDTH-1:0] m_tgt [SETS*WAYS];
   logic [1:0]            m_kind [SETS*WAYS];
   logic [1:0]            m_tr [SETS*WAYS];
   logic                  m_valid [SETS*WAYS];
   int                    m_age [SETS*WAYS];
   logic [ADDR_WIDTH-1:0] ind_tgt [IND_N];
   logic [11:0]           dir_hist;
   logic [ADDR_WIDTH-1:0] ras [DEPTH];
   int                    ras_top, ras_cnt;
   logic [3:0]            size_tbl [CSN];
   logic [ADDR_WIDTH-1:0] last_ip;
   logic [1:0]            last_tr;

   rsp_type expected_q[$];
   int      errors = 0;
   longint  cycles = 0;
   bit      idle_on = 1'b1;
   logic [ADDR_WIDTH-1:0] hot_ip[$];

   task automatic report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void refresh_age(int base, int w);
      int old;
      old = m_valid[base+w] ? m_age[base+w] : WAYS;
      for (int v = 0; v < WAYS; v++)
         if (v != w && m_valid[base+v] && m_age[base+v] < old) m_age[base+v]++;
      m_age[base+w] = 0;
   endfunction

   function automatic void predict_btb(input req_type r);
      logic [KEY_WIDTH-1:0] key;
      int base, w, best;
      rsp_type e;
      logic [ADDR_WIDTH-1:0] ra, cip, d, mag;
      logic [1:0] tr, kind;
      logic is_call, is_ind, is_cond;
      key = last_ip[63:2];
      base = int'(key % SETS) * WAYS;
      w = WAYS;
      for (int v = WAYS-1; v >= 0; v--)
         if (m_valid[base+v] && m_key[base+v] == key && m_tr[base+v] == last_tr) w = v;
      if (r.mode == MODE_PREDICT) begin
         e = '0;
         if (w < WAYS) begin
            refresh_age(base, w);
            e.hit = 1'b1;
            e.pred_target = m_tgt[base+w];
            if (m_kind[base+w] == K_RETURN) begin
               e.unconditional = 1'b1;
               if (ras_cnt == 0) e.pred_target = '0;
               else begin
                  ra = ras[ras_top];
                  e.pred_target = ra + size_tbl[ra % CSN];
               end
            end else if (m_kind[base+w] == K_INDIRECT) begin
               e.pred_target = ind_tgt[((r.ip >> 2) ^ dir_hist) % IND_N];
               e.unconditional = 1'b1;
            end else if (m_kind[base+w] != K_COND) begin
               e.unconditional = 1'b1;
            end
         end
         expected_q = {expected_q, e};
         return;
      end
      is_call = r.branch_kind == BK_CALL || r.branch_kind == BK_IND_CALL;
      is_ind  = r.branch_kind == BK_INDIRECT || r.branch_kind == BK_IND_CALL;
      is_cond = r.branch_kind == BK_COND || r.branch_kind == BK_OTHER;
      if (is_call) tr = TR_CALL;
      else if (r.taken && r.branch_kind != BK_RETURN) tr = TR_TAKEN;
      else tr = TR_NOT;
      if (is_call) begin
         ras_top = (ras_top + 1) % DEPTH;
         ras[ras_top] = r.ip;
         if (ras_cnt < DEPTH) ras_cnt++;
      end
      if (r.branch_kind == BK_RETURN && ras_cnt > 0) begin
         cip = ras[ras_top];
         d = cip - r.resolved_target;
         ras_top = (ras_top + DEPTH - 1) % DEPTH;
         ras_cnt--;
         mag = d[63] ? -d : d;
         if (mag <= SIZE_LIMIT) size_tbl[cip % CSN] = mag[3:0];
      end
      if (is_ind) ind_tgt[((r.ip >> 2) ^ dir_hist) % IND_N] = r.resolved_target;
      if (is_cond) dir_hist = {dir_hist[10:0], r.taken};
      if (is_ind) kind = K_INDIRECT;
      else if (r.branch_kind == BK_RETURN) kind = K_RETURN;
      else if (is_cond) kind = K_COND;
      else kind = K_ALWAYS;
      if (w < WAYS) begin
         refresh_age(base, w);
         if (r.resolved_target != 0) begin
            m_tgt[base+w] = r.resolved_target;
            m_kind[base+w] = kind;
         end
      end else if (r.resolved_target != 0) begin
         best = -1;
         for (int v = WAYS-1; v >= 0; v--) if (!m_valid[base+v]) best = v;
         if (best < 0) begin
            best = 0;
            for (int v = 1; v < WAYS; v++) if (m_age[base+v] > m_age[base+best]) best = v;
         end
         refresh_age(base, best);
         m_valid[base+best] = 1'b1;
         m_key[base+best] = key;
         m_tr[base+best] = last_tr;
         m_tgt[base+best] = r.resolved_target;
         m_kind[base+best] = kind;
      end
      last_ip = r.ip;
      last_tr = tr;
   endfunction

   task automatic idle_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_request(input req_type r);
      idle_gap();
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_btb(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic req_type make_req(logic mode, logic [63:0] ip, logic [63:0] tgt,
                                        logic tk, logic [2:0] bk);
      req_type r;
      r.mode = mode; r.ip = ip; r.resolved_target = tgt; r.taken = tk; r.branch_kind = bk;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) report("response with no request outstanding");
         else begin
            rsp_type e;
            e = expected_q[0];
            expected_q.delete(0);
            if (rsp_data.pred_target !== e.pred_target)
               report($sformatf("target %h expected %h", rsp_data.pred_target,
                                e.pred_target));
            if (rsp_data.unconditional !== e.unconditional)
               report($sformatf("unconditional %b expected %b", rsp_data.unconditional,
                                e.unconditional));
            if (rsp_data.hit !== e.hit)
               report($sformatf("hit %b expected %b", rsp_data.hit, e.hit));
         end
      end
   end

   task automatic test_directed();
      send_request(make_req(MODE_PREDICT, '0, '0, 1'b0, BK_JUMP));
      send_request(make_req(MODE_UPDATE, '0, 64'h1000, 1'b1, BK_JUMP));
      send_request(make_req(MODE_UPDATE, 64'h1000, 64'h2000, 1'b1, BK_UNUSED));
      send_request(make_req(MODE_UPDATE, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, BK_COND));
      send_request(make_req(MODE_UPDATE, '1, 64'h40, 1'b1, BK_CALL));
      send_request(make_req(MODE_UPDATE, 64'h40, 64'h48, 1'b0, BK_RETURN));
      send_request(make_req(MODE_UPDATE, '1, 64'h40, 1'b1, BK_CALL));
      send_request(make_req(MODE_PREDICT, 64'h40, '0, 1'b0, BK_JUMP));
      send_request(make_req(MODE_UPDATE, 64'h40, 64'h0, 1'b1, BK_RETURN));
      send_request(make_req(MODE_UPDATE, 64'h44, 64'h0, 1'b1, BK_RETURN));
      send_request(make_req(MODE_UPDATE, 64'h80, 64'h300, 1'b1, BK_INDIRECT));
      send_request(make_req(MODE_UPDATE, 64'h300, 64'h700, 1'b1, BK_IND_CALL));
      send_request(make_req(MODE_UPDATE, 64'h704, '1, 1'b1, BK_OTHER));
      send_request(make_req(MODE_PREDICT, '1, '0, 1'b1, BK_OTHER));
      drain();
   endtask

   task automatic test_stack_overflow();
      for (int i = 0; i < DEPTH + 6; i++)
         send_request(make_req(MODE_UPDATE, 64'h5000 + 64'(16*i), 64'h9000, 1'b1, BK_CALL));
      for (int i = 0; i < DEPTH + 4; i++) begin
         send_request(make_req(MODE_UPDATE, 64'h9000, 64'h5004 + 64'(16*(DEPTH+5-i)),
                               1'b1, BK_RETURN));
         send_request(make_req(MODE_PREDICT, 64'h9000, '0, 1'b0, BK_JUMP));
      end
      drain();
   endtask

   task automatic test_random_flow();
      req_type r;
      logic [63:0] ip, tgt;
      for (int n = 0; n < 720; n++) begin
         if (n == 620) idle_on = 1'b0;
         if (hot_ip.size() < 24 || $urandom_range(0, 9) == 0) hot_ip = {hot_ip, rand64()};
         ip = $urandom_range(0, 4) == 0 ? rand64() : hot_ip[$urandom_range(0, hot_ip.size()-1)];
         case ($urandom_range(0, 3))
            0: tgt = '0;
            1: tgt = ip + 64'($urandom_range(0, 20)) - 64'd10;
            default: tgt = hot_ip[$urandom_range(0, hot_ip.size()-1)];
         endcase
         r = make_req($urandom_range(0, 2) == 0 ? MODE_PREDICT : MODE_UPDATE, ip, tgt,
                      1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         send_request(r);
         // predict from the same point to exercise lookups hitting trained entries
         if ($urandom_range(0, 1)) send_request(make_req(MODE_PREDICT, rand64(), '0,
                                               1'($urandom_range(0, 1)),
                                               3'($urandom_range(0, 7))));
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < SETS*WAYS; i++) begin
         m_valid[i] = 1'b0; m_age[i] = 0; m_key[i] = '0; m_tgt[i] = '0;
         m_kind[i] = '0; m_tr[i] = '0;
      end
      for (int i = 0; i < IND_N; i++) ind_tgt[i] = '0;
      for (int i = 0; i < DEPTH; i++) ras[i] = '0;
      for (int i = 0; i < CSN; i++) size_tbl[i] = SIZE_RESET;
      dir_hist = '0; ras_top = 0; ras_cnt = 0; last_ip = '0; last_tr = TR_NOT;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_stack_overflow();
      test_random_flow();
      if (errors == 0 && expected_q.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
